@@ design/cfa_pkg.sv @@
// ---------------------------------------------------------------------------
// cfa_pkg: shared types and constants for the contiguous frame allocator
// Frame state codes, command and status codes, register indexes, widths
// and the structs passed between the allocator's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

   localparam int MAX_FRAMES = 1024;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   // counts must hold MAX_FRAMES itself and the 11-bit field values
   localparam int CNT_W      = (IDX_W + 1 > 11) ? IDX_W + 1 : 11;

   localparam int FRAME_W    = 20;
   localparam int LEN_W      = 11;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [FRAME_W-1:0] POOL_BASE_RST   = '0;
   localparam logic [LEN_W-1:0]   POOL_FRAMES_RST = 11'd1024;

   // per-frame state codes
   localparam logic [1:0] FS_FREE = 2'h0;
   localparam logic [1:0] FS_USED = 2'h1;
   localparam logic [1:0] FS_HEAD = 2'h2;

   // commands
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

   // result status
   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_TOO_FEW  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NO_FIT   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_OUTSIDE  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NOT_HEAD = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POOL_BASE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POOL_FRAMES = 1'd1;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FRAME_W-1:0] frame_no;
      logic [LEN_W-1:0]   run_length;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [FRAME_W-1:0] first_frame;
      logic [LEN_W-1:0]   free_count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   typedef struct packed {
      logic               wipe;
      logic [FRAME_W-1:0] pool_base;
      logic [CNT_W-1:0]   pool_size;
   } cfg_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [1:0]       wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

@@ design/contiguous_frame_allocator.sv @@
// ---------------------------------------------------------------------------
// contiguous_frame_allocator: first-fit contiguous frame allocator
// Two-bit state per frame in a RAM; allocate, release, reserve and clear
// commands, one result beat per command not cut short by a register write.
// ---------------------------------------------------------------------------
// One command is handled at a time; the frame state RAM is read and
// written once per cycle, so the frame sweep sets the latency. Allocate
// scans frames from the pool start (up to the pool size) and then writes
// each frame of the run; release reads the head, frees it and then reads
// each frame after it, freeing each used frame up to the frame that ends
// the run, if any; reserve reads and marks each frame of the run. Commands
// rejected before any RAM access (too few free, zero length, outside pool)
// end without a sweep, a release of a non-head frame after reading it.
// Clear, any register write and reset start a clearing pass over all
// MAX_FRAMES (1024) frames, during which req_tready is low. The result beat
// waits in an output register, so the next command is accepted while it is
// pending; a further result holds the engine until that register is free.
`default_nettype none

module contiguous_frame_allocator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request: tdata = frame_no[19:0], run_length[30:20], zero pad [31]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [31:0]                        req_tdata,
   // request: tuser = command[1:0]
   input  wire logic [cfa_pkg::CMD_W-1:0]          req_tuser,
   // response: tdata = status[2:0], first_frame[22:3], free_count[33:23],
   // zero pad [39:34]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [39:0]                             rsp_tdata,
   input  wire logic                               csr_wr_en,
   input  wire logic [cfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cfa_pkg::*;

   logic [FRAME_W-1:0] pool_base_ff, pool_base_in;
   logic [LEN_W-1:0]   pool_frames_ff, pool_frames_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   cfg_type     cfg;
   req_type     req;
   mem_req_type mem;
   res_type     res;
   logic [1:0]  mem_rd_data;
   logic        out_free;

   always_comb begin
      pool_base_in   = pool_base_ff;
      pool_frames_in = pool_frames_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_POOL_BASE:   pool_base_in   = csr_wdata[FRAME_W-1:0];
            REG_POOL_FRAMES: pool_frames_in = csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   assign cfg.wipe      = csr_wr_en;
   assign cfg.pool_base = pool_base_ff;
   assign cfg.pool_size = (CNT_W'(pool_frames_ff) > CNT_W'(MAX_FRAMES)) ?
                          CNT_W'(MAX_FRAMES) : CNT_W'(pool_frames_ff);

   assign req.command    = req_tuser;
   assign req.frame_no   = req_tdata[19:0];
   assign req.run_length = req_tdata[30:20];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= POOL_BASE_RST;
         pool_frames_ff <= POOL_FRAMES_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pool_base_ff   <= pool_base_in;
         pool_frames_ff <= pool_frames_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.free_count, rsp_data_ff.first_frame,
                        rsp_data_ff.status};

   cfa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .mem         (mem),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .res         (res)
   );

   cfa_ram #(
      .WIDTH (2),
      .DEPTH (MAX_FRAMES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef NO_ASSERTIONS
   // the engine hands over a result only into a free output register
   a_res_into_free : assert property (@(posedge clock) disable iff (reset)
      res.valid |-> out_free)
      else $error("result produced while output register busy");

   // first_frame is zero unless the command succeeded
   a_first_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STAT_OK) |-> rsp_data_ff.first_frame == '0)
      else $error("first_frame nonzero on failed command");

   // reported free frames never exceed the pool
   a_free_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_data_ff.free_count) <= 32'(cfg.pool_size))
      else $error("free_count above pool size");

   // a register write starts the clearing pass, so no command is taken next
   a_wipe_blocks : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("command accepted right after register write");
`endif

endmodule

`default_nettype wire

@@ design/cfa_ram.sv @@
// ---------------------------------------------------------------------------
// cfa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cfa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/cfa_engine.sv @@
// ---------------------------------------------------------------------------
// cfa_engine: command sequencer over the frame state RAM
// Runs the clearing pass, the first-fit scan and the read-modify-write
// sweeps of release and reserve, one frame per cycle, and keeps the count
// of non-free frames.
// ---------------------------------------------------------------------------
`default_nettype none

module cfa_engine (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfa_pkg::cfg_type cfg,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire cfa_pkg::req_type req,
   output cfa_pkg::mem_req_type mem,
   input  wire logic [1:0]      mem_rd_data,
   input  wire logic            out_free,
   output cfa_pkg::res_type     res
);
   import cfa_pkg::*;

   typedef enum logic [7:0] {
      S_WIPE    = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_AL_SCAN = 8'b0000_0100,
      S_AL_WR   = 8'b0000_1000,
      S_RL_CHK  = 8'b0001_0000,
      S_RL_RUN  = 8'b0010_0000,
      S_RS_RUN  = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;       // wipe / write pointer
   logic [IDX_W-1:0]   dpos_ff, dpos_in;     // address of data now on the read port
   logic [IDX_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [FRAME_W-1:0] first_ff, first_in;
   logic               from_cmd_ff, from_cmd_in;

   logic [CNT_W-1:0]   free_cnt;
   logic [CNT_W-1:0]   nxt_cnt;
   logic [CNT_W-1:0]   req_len;
   logic [FRAME_W-1:0] diff;
   logic               in_pool;
   logic               found;

   assign free_cnt = cfg.pool_size - used_ff;
   assign nxt_cnt  = CNT_W'(dpos_ff) + CNT_W'(1);
   assign req_len  = CNT_W'(req.run_length);
   assign diff     = req.frame_no - cfg.pool_base;
   assign in_pool  = (req.frame_no >= cfg.pool_base) &&
                     (32'(diff) < 32'(cfg.pool_size));
   assign found    = (mem_rd_data == FS_FREE) && (run_ff + CNT_W'(1) == len_ff);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      dpos_in     = dpos_ff;
      start_in    = start_ff;
      run_in      = run_ff;
      used_in     = used_ff;
      len_in      = len_ff;
      status_in   = status_ff;
      first_in    = first_ff;
      from_cmd_in = from_cmd_ff;
      mem         = '0;
      res.valid   = 1'b0;
      res.data.status      = status_ff;
      res.data.first_frame = first_ff;
      res.data.free_count  = LEN_W'(free_cnt);

      unique case (state_ff)
         S_WIPE: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = pos_ff;
            mem.wr_data = FS_FREE;
            used_in     = '0;
            pos_in      = pos_ff + IDX_W'(1);
            if (pos_ff == IDX_W'(MAX_FRAMES - 1)) begin
               pos_in    = '0;
               status_in = STAT_OK;
               first_in  = '0;
               state_in  = from_cmd_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               status_in = STAT_OK;
               first_in  = '0;
               len_in    = req_len;
               run_in    = '0;
               start_in  = '0;
               unique case (req.command)
                  CMD_ALLOC: begin
                     if (req_len > free_cnt) begin
                        status_in = STAT_TOO_FEW;
                        state_in  = S_DONE;
                     end else if (req_len == '0) begin
                        status_in = STAT_NO_FIT;
                        state_in  = S_DONE;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = '0;
                        dpos_in     = '0;
                        state_in    = S_AL_SCAN;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!in_pool) begin
                        status_in = STAT_OUTSIDE;
                        state_in  = S_DONE;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = diff[IDX_W-1:0];
                        dpos_in     = diff[IDX_W-1:0];
                        state_in    = S_RL_CHK;
                     end
                  end
                  CMD_RESERVE: begin
                     if (!in_pool) begin
                        status_in = STAT_OUTSIDE;
                        state_in  = S_DONE;
                     end else if (req_len == '0) begin
                        state_in = S_DONE;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = diff[IDX_W-1:0];
                        dpos_in     = diff[IDX_W-1:0];
                        state_in    = S_RS_RUN;
                     end
                  end
                  CMD_CLEAR: begin
                     pos_in      = '0;
                     from_cmd_in = 1'b1;
                     state_in    = S_WIPE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_AL_SCAN: begin
            if (found) begin
               pos_in   = start_ff;
               state_in = S_AL_WR;
            end else begin
               if (mem_rd_data == FS_FREE) begin
                  run_in = run_ff + CNT_W'(1);
               end else begin
                  run_in   = '0;
                  start_in = dpos_ff + IDX_W'(1);
               end
               if (nxt_cnt == cfg.pool_size) begin
                  status_in = STAT_NO_FIT;
                  state_in  = S_DONE;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = nxt_cnt[IDX_W-1:0];
                  dpos_in     = nxt_cnt[IDX_W-1:0];
               end
            end
         end
         S_AL_WR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = pos_ff;
            mem.wr_data = (pos_ff == start_ff) ? FS_HEAD : FS_USED;
            pos_in      = pos_ff + IDX_W'(1);
            if (CNT_W'(pos_ff) + CNT_W'(1) == CNT_W'(start_ff) + len_ff) begin
               used_in  = used_ff + len_ff;
               first_in = cfg.pool_base + FRAME_W'(start_ff);
               state_in = S_DONE;
            end
         end
         S_RL_CHK: begin
            if (mem_rd_data != FS_HEAD) begin
               status_in = STAT_NOT_HEAD;
               state_in  = S_DONE;
            end else begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = dpos_ff;
               mem.wr_data = FS_FREE;
               if (used_ff != '0) used_in = used_ff - CNT_W'(1);
               if (nxt_cnt < cfg.pool_size) begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = nxt_cnt[IDX_W-1:0];
                  dpos_in     = nxt_cnt[IDX_W-1:0];
                  state_in    = S_RL_RUN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RL_RUN: begin
            // write of this frame and read of the next never share an address
            if (mem_rd_data == FS_USED) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = dpos_ff;
               mem.wr_data = FS_FREE;
               if (used_ff != '0) used_in = used_ff - CNT_W'(1);
               if (nxt_cnt < cfg.pool_size) begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = nxt_cnt[IDX_W-1:0];
                  dpos_in     = nxt_cnt[IDX_W-1:0];
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_RS_RUN: begin
            if (mem_rd_data == FS_FREE) used_in = used_ff + CNT_W'(1);
            mem.wr_en   = 1'b1;
            mem.wr_addr = dpos_ff;
            mem.wr_data = (run_ff == '0) ? FS_HEAD : FS_USED;
            run_in      = run_ff + CNT_W'(1);
            if ((run_ff + CNT_W'(1) < len_ff) && (nxt_cnt < cfg.pool_size)) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = nxt_cnt[IDX_W-1:0];
               dpos_in     = nxt_cnt[IDX_W-1:0];
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res.valid   = 1'b1;
               from_cmd_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a register write reinitializes the pool
      if (cfg.wipe) begin
         state_in    = S_WIPE;
         pos_in      = '0;
         from_cmd_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_WIPE;
         pos_ff      <= '0;
         used_ff     <= '0;
         from_cmd_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         used_ff     <= used_in;
         from_cmd_ff <= from_cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      dpos_ff   <= dpos_in;
      start_ff  <= start_in;
      run_ff    <= run_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      first_ff  <= first_in;
   end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for contiguous_frame_allocator
// A directed table covers empty, full and wrapped pools and every status
// code. Random phases under varied pool settings follow. Each beat is
// checked against a fixed result or an in-bench mirror of the frame store.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfa_pkg::*;

   typedef struct packed {
      logic                  is_reg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      req_type               req;
      logic                  has_fixed;
      rsp_type               fixed;
   } row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // frame_no[19:0], run_length[30:20], zero pad [31]
   logic [31:0]           req_tdata  = '0;
   // command[1:0]
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // status[2:0], first_frame[22:3], free_count[33:23], zero pad [39:34]
   logic [39:0]           rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   contiguous_frame_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // mirror of the frame store and pool registers
   logic [1:0]         frame_mirror [0:MAX_FRAMES-1];
   int                 used_frames;
   logic [FRAME_W-1:0] cfg_base   = POOL_BASE_RST;
   logic [LEN_W-1:0]   cfg_frames = POOL_FRAMES_RST;

   rsp_type pending_rsp [$];
   row_type directed_rows [$];

   int mismatches  = 0;
   int beats_seen  = 0;
   int reqs_sent   = 0;
   int reg_writes  = 0;
   int status_seen [0:7];
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_timer = 0;
   int stall_cyc   = 0;
   rsp_type got, want;

   function automatic int pool_size();
      return (int'(cfg_frames) > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_frames);
   endfunction

   function automatic rsp_type mk_rsp(logic [STAT_W-1:0] st, logic [FRAME_W-1:0] ff,
                                      logic [LEN_W-1:0] fc);
      rsp_type r;
      r.status      = st;
      r.first_frame = ff;
      r.free_count  = fc;
      return r;
   endfunction

   task automatic wipe_pool();
      int i;
      for (i = 0; i < MAX_FRAMES; i++) frame_mirror[i] = FS_FREE;
      used_frames = 0;
   endtask

   // expected result of one command, updating the mirror
   task automatic apply_cmd(input req_type it, output rsp_type res);
      int size, len, freec, run, start, idx, f, b, i;
      bit found;
      logic [STAT_W-1:0]  st;
      logic [FRAME_W-1:0] first;
      size  = pool_size();
      len   = int'(it.run_length);
      f     = int'(it.frame_no);
      b     = int'(cfg_base);
      st    = STAT_OK;
      first = '0;
      found = 1'b0;
      idx   = 0;
      if (used_frames > size) used_frames = size;
      case (it.command)
         CMD_ALLOC: begin
            freec = size - used_frames;
            if (freec < len) begin
               st = STAT_TOO_FEW;
            end else begin
               run   = 0;
               start = 0;
               if (len != 0) begin
                  for (i = 0; i < size && !found; i++) begin
                     if (frame_mirror[i] == FS_FREE) begin
                        run++;
                        if (run == len) found = 1'b1;
                     end else begin
                        run   = 0;
                        start = i + 1;
                     end
                  end
               end
               if (found) begin
                  frame_mirror[start] = FS_HEAD;
                  for (i = start + 1; i < start + len; i++) frame_mirror[i] = FS_USED;
                  used_frames += len;
                  first = FRAME_W'(b + start);
               end else begin
                  st = STAT_NO_FIT;
               end
            end
         end
         CMD_RELEASE: begin
            if (f < b || f - b >= size) begin
               st = STAT_OUTSIDE;
            end else begin
               idx = f - b;
               if (frame_mirror[idx] != FS_HEAD) begin
                  st = STAT_NOT_HEAD;
               end else begin
                  frame_mirror[idx] = FS_FREE;
                  if (used_frames > 0) used_frames--;
                  for (i = idx + 1; i < size && frame_mirror[i] == FS_USED; i++) begin
                     frame_mirror[i] = FS_FREE;
                     if (used_frames > 0) used_frames--;
                  end
               end
            end
         end
         CMD_RESERVE: begin
            if (f < b || f - b >= size) begin
               st = STAT_OUTSIDE;
            end else begin
               idx = f - b;
               // overwrites whatever is there; only free frames add to the count
               for (i = 0; i < len && idx + i < size; i++) begin
                  if (frame_mirror[idx + i] == FS_FREE) used_frames++;
                  frame_mirror[idx + i] = (i == 0) ? FS_HEAD : FS_USED;
               end
            end
         end
         default: wipe_pool();
      endcase
      if (used_frames > size) used_frames = size;
      res = mk_rsp(st, first, LEN_W'(size - used_frames));
   endtask

   task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] frame,
                          input logic [LEN_W-1:0] len, input logic has_fixed,
                          input rsp_type fixed);
      row_type r;
      r                = '0;
      r.req.command    = cmd;
      r.req.frame_no   = frame;
      r.req.run_length = len;
      r.has_fixed      = has_fixed;
      r.fixed          = fixed;
      directed_rows.push_back(r);
   endtask

   task automatic add_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      row_type r;
      r          = '0;
      r.is_reg   = 1'b1;
      r.reg_idx  = idx;
      r.reg_data = data;
      directed_rows.push_back(r);
   endtask

   // register writes only with nothing in flight and the clearing pass done
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_POOL_BASE) cfg_base = data;
      else cfg_frames = data[LEN_W-1:0];
      wipe_pool();
      reg_writes++;
      // give the clearing pass time to pull tready low
      repeat (4) @(posedge clock);
   endtask

   task automatic send_request(input req_type it, input logic has_fixed, input rsp_type fixed);
      int gap;
      rsp_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it.run_length, it.frame_no};
      req_tuser  <= it.command;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_cmd(it, res);
      pending_rsp.push_back(has_fixed ? fixed : res);
      reqs_sent++;
   endtask

   // mostly well-formed traffic: releases aim at live heads, sizes fit the pool
   task automatic gen_request(output req_type it);
      int size, r, k, hi, heads, idx, i;
      size          = pool_size();
      hi            = (size / 4 > 0) ? size / 4 : 1;
      it.command    = CMD_ALLOC;
      it.frame_no   = FRAME_W'($urandom);
      it.run_length = LEN_W'($urandom_range(0, 2047));
      r             = $urandom_range(0, 99);
      k             = $urandom_range(0, 19);
      if (r < 42) begin
         if (k < 14) it.run_length = LEN_W'($urandom_range(1, hi));
         else if (k < 17) it.run_length = LEN_W'($urandom_range(0, size + 2));
         else if (k == 19) it.run_length = '0;
      end else if (r < 72) begin
         it.command = CMD_RELEASE;
         heads = 0;
         for (i = 0; i < size; i++) if (frame_mirror[i] == FS_HEAD) heads++;
         if (k < 15 && heads > 0) begin
            idx = $urandom_range(0, heads - 1);
            for (i = 0; i < size; i++) begin
               if (frame_mirror[i] == FS_HEAD) begin
                  if (idx == 0) it.frame_no = FRAME_W'(int'(cfg_base) + i);
                  idx--;
               end
            end
         end else if (k < 18 && size > 0) begin
            it.frame_no = FRAME_W'(int'(cfg_base) + int'($urandom_range(0, size - 1)));
         end
      end else if (r < 90) begin
         it.command = CMD_RESERVE;
         if (k < 16 && size > 0) begin
            it.frame_no   = FRAME_W'(int'(cfg_base) + int'($urandom_range(0, size - 1)));
            it.run_length = LEN_W'($urandom_range(0, (size / 3 > 0) ? size / 3 : 1));
         end
      end else if (r < 93) begin
         it.command = CMD_CLEAR;
      end else begin
         it.command = CMD_W'($urandom_range(0, 3));
      end
   endtask

   // result check and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tdata[2:0];
         got.first_frame = rsp_tdata[22:3];
         got.free_count  = rsp_tdata[33:23];
         beats_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: status %0d first_frame %h free_count %0d",
                        got.status, got.first_frame, got.free_count);
         end else begin
            want = pending_rsp.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status || got.first_frame !== want.first_frame ||
                got.free_count !== want.free_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d exp st %0d ff %h fc %0d, got st %0d ff %h fc %0d",
                           beats_seen, want.status, want.first_frame, want.free_count,
                           got.status, got.first_frame, got.free_count);
            end
         end
      end
      stall_cyc++;
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_timer = $urandom_range(20, 300);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 9) < 3);
         default: rsp_tready <= (stall_cyc % 7 != 3) && (stall_cyc % 7 != 4);
      endcase
   end

   initial begin
      row_type            row;
      req_type            it;
      logic [CSR_DATA_W-1:0] base_val, frames_val;
      int                 p, n, i;
      for (i = 0; i < 8; i++) status_seen[i] = 0;
      wipe_pool();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full default pool
      add_cmd(CMD_ALLOC,   20'h00000, 11'd0,    1'b1, mk_rsp(STAT_NO_FIT,   '0, 11'd1024));
      add_cmd(CMD_ALLOC,   20'hFFFFF, 11'h7FF,  1'b1, mk_rsp(STAT_TOO_FEW,  '0, 11'd1024));
      add_cmd(CMD_ALLOC,   20'h00000, 11'd1024, 1'b1, mk_rsp(STAT_OK,       '0, 11'd0));
      add_cmd(CMD_ALLOC,   20'h00000, 11'd1,    1'b1, mk_rsp(STAT_TOO_FEW,  '0, 11'd0));
      add_cmd(CMD_RELEASE, 20'd5,     11'd0,    1'b1, mk_rsp(STAT_NOT_HEAD, '0, 11'd0));
      add_cmd(CMD_RELEASE, 20'd0,     11'd0,    1'b1, mk_rsp(STAT_OK,       '0, 11'd1024));
      add_cmd(CMD_RELEASE, 20'd1024,  11'd0,    1'b1, mk_rsp(STAT_OUTSIDE,  '0, 11'd1024));
      add_cmd(CMD_RESERVE, 20'hFFFFF, 11'd1,    1'b1, mk_rsp(STAT_OUTSIDE,  '0, 11'd1024));
      add_cmd(CMD_RESERVE, 20'd10,    11'd0,    1'b1, mk_rsp(STAT_OK,       '0, 11'd1024));
      // run cut at pool end
      add_cmd(CMD_RESERVE, 20'd1020,  11'd10,   1'b1, mk_rsp(STAT_OK,       '0, 11'd1020));
      add_cmd(CMD_ALLOC,   20'h00000, 11'd3,    1'b1, mk_rsp(STAT_OK,       '0, 11'd1017));
      // reserve over a live run, a release that stops at the new head, then one of the new run
      add_cmd(CMD_RESERVE, 20'd1,     11'd4,    1'b0, '0);
      add_cmd(CMD_RELEASE, 20'd0,     11'd0,    1'b0, '0);
      add_cmd(CMD_RELEASE, 20'd1,     11'd0,    1'b0, '0);
      add_cmd(CMD_ALLOC,   20'h00000, 11'd700,  1'b0, '0);
      add_cmd(CMD_RESERVE, 20'd800,   11'd1,    1'b0, '0);
      add_cmd(CMD_ALLOC,   20'h00000, 11'd200,  1'b0, '0);
      add_cmd(CMD_CLEAR,   20'h00000, 11'd0,    1'b1, mk_rsp(STAT_OK,       '0, 11'd1024));
      // 8-frame pool at the top of the frame space: first_frame wraps
      add_reg(REG_POOL_BASE,   20'hFFFFC);
      add_reg(REG_POOL_FRAMES, 20'h00008);
      add_cmd(CMD_ALLOC,   20'h00000, 11'd6,    1'b1, mk_rsp(STAT_OK,       20'hFFFFC, 11'd2));
      add_cmd(CMD_ALLOC,   20'h00000, 11'd2,    1'b1, mk_rsp(STAT_OK,       20'h00002, 11'd0));
      add_cmd(CMD_RELEASE, 20'h00002, 11'd0,    1'b1, mk_rsp(STAT_OUTSIDE,  '0, 11'd0));
      add_cmd(CMD_RELEASE, 20'hFFFFC, 11'd0,    1'b1, mk_rsp(STAT_OK,       '0, 11'd6));
      // upper data bits are dropped: empty pool
      add_reg(REG_POOL_FRAMES, 20'hFF800);
      add_cmd(CMD_ALLOC,   20'h00000, 11'd0,    1'b1, mk_rsp(STAT_NO_FIT,   '0, 11'd0));
      add_cmd(CMD_ALLOC,   20'h00000, 11'd1,    1'b1, mk_rsp(STAT_TOO_FEW,  '0, 11'd0));
      add_cmd(CMD_RESERVE, 20'hFFFFC, 11'd1,    1'b1, mk_rsp(STAT_OUTSIDE,  '0, 11'd0));
      add_cmd(CMD_CLEAR,   20'h00000, 11'd0,    1'b1, mk_rsp(STAT_OK,       '0, 11'd0));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_reg) write_reg(row.reg_idx, row.reg_data);
         else send_request(row.req, row.has_fixed, row.fixed);
      end

      for (p = 0; p < 12; p++) begin
         case (p)
            0:       frames_val = 20'd1;
            1:       frames_val = 20'd4;
            2:       frames_val = 20'd16;
            3:       frames_val = 20'd1024;
            4:       frames_val = 20'd37;
            5:       frames_val = 20'd64;
            6:       frames_val = 20'hFFFFF;   // above store depth
            7:       frames_val = 20'd100;
            8:       frames_val = 20'd8;
            9:       frames_val = 20'd0;
            10:      frames_val = 20'd200;
            default: frames_val = 20'd5;
         endcase
         case (p % 4)
            0:       base_val = 20'h00000;
            1:       base_val = CSR_DATA_W'(32'h000FFFFF - $urandom_range(0, 40));
            default: base_val = CSR_DATA_W'($urandom_range(0, 32'h000FFFFF));
         endcase
         if (p % 2) begin
            write_reg(REG_POOL_FRAMES, frames_val);
            write_reg(REG_POOL_BASE, base_val);
         end else begin
            write_reg(REG_POOL_BASE, base_val);
            write_reg(REG_POOL_FRAMES, frames_val);
         end
         for (n = 0; n < 46; n++) begin
            gen_request(it);
            send_request(it, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      $display("covered %0d commands, %0d register writes, %0d result beats",
               reqs_sent, reg_writes, beats_seen);
      $display("status mix: ok %0d, too few %0d, no fit %0d, outside %0d, not head %0d",
               status_seen[STAT_OK], status_seen[STAT_TOO_FEW], status_seen[STAT_NO_FIT],
               status_seen[STAT_OUTSIDE], status_seen[STAT_NOT_HEAD]);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(150_000_000);
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
